>>> rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked while reset is asserted
`define CHK_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, masked while reset is asserted
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// next-cycle implication that also holds across reset
`define CHK_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/iaf_pkg.sv
`default_nettype none

package iaf_pkg;

    // digit store geometry
    localparam int unsigned BIN_BITS = 64;
    localparam int unsigned DEC_DIGITS = 20;
    localparam int unsigned HEX_DIGITS = 16;
    localparam int unsigned BCD_BITS = DEC_DIGITS * 4;

    localparam logic [4:0] REM_DEC = 5'(DEC_DIGITS);
    localparam logic [4:0] REM_HEX = 5'(HEX_DIGITS);

    // ascii bases
    localparam logic [6:0] ASCII_ZERO = 7'd48;
    localparam logic [6:0] ASCII_UPPER_A = 7'd65;
    localparam logic [6:0] TEN = 7'd10;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic hex;
        logic dabble;
        logic skip;
        logic emit;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic top_zero;
        logic rem_one;
        logic out_free;
    } t_sts;

    // one digit to its ascii code
    function automatic logic [6:0] digit_to_ascii(input logic [3:0] d);
        logic [6:0] code;
        if ({3'b000, d} < TEN) begin
            code = ASCII_ZERO + {3'b000, d};
        end else begin
            code = ASCII_UPPER_A + {3'b000, d} - TEN;
        end
        return code;
    endfunction

endpackage

`default_nettype wire

>>> rtl/iaf_ctrl.sv
`default_nettype none

module iaf_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic          i_func,
    output logic               o_stall,
    input  wire iaf_pkg::t_sts i_sts,
    output iaf_pkg::t_cmd      o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_SKIP = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic [5:0] r_bit_cnt;
    logic [5:0] n_bit_cnt;

    assign o_stall = (r_state != ST_IDLE);

    // command decode and next state
    always_comb begin
        o_cmd = '0;
        o_cmd.hex = i_func;
        n_state = r_state;
        n_bit_cnt = r_bit_cnt;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_bit_cnt = '0;
                    n_state = i_func ? ST_SKIP : ST_CONV;
                end
            end
            ST_CONV: begin
                o_cmd.dabble = 1'b1;
                n_bit_cnt = r_bit_cnt + 6'd1;
                if (r_bit_cnt == 6'd63) begin
                    n_state = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (i_sts.top_zero && !i_sts.rem_one) begin
                    o_cmd.skip = 1'b1;
                end else if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = i_sts.rem_one ? ST_IDLE : ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.rem_one) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_bit_cnt <= '0;
        end else begin
            r_state <= n_state;
            r_bit_cnt <= n_bit_cnt;
        end
    end

endmodule

`default_nettype wire

>>> rtl/iaf_dp.sv
`default_nettype none

module iaf_dp (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire iaf_pkg::t_cmd i_cmd,
    input  wire logic [63:0]   i_value,
    output iaf_pkg::t_sts      o_sts,
    output logic               o_valid,
    output logic [6:0]         o_char_code,
    output logic               o_last,
    input  wire logic          i_stall
);

    logic [iaf_pkg::BIN_BITS-1:0] r_bin;
    logic [iaf_pkg::BCD_BITS-1:0] r_bcd;
    logic [iaf_pkg::BCD_BITS-1:0] adj_bcd;
    logic [4:0]                   r_rem;
    logic [3:0]                   top_digit;

    assign top_digit = r_bcd[iaf_pkg::BCD_BITS-1 -: 4];

    // status towards the controller
    assign o_sts.top_zero = (top_digit == 4'd0);
    assign o_sts.rem_one  = (r_rem == 5'd1);
    assign o_sts.out_free = !o_valid || !i_stall;

    // add-three correction on every bcd digit
    always_comb begin
        for (int i = 0; i < iaf_pkg::DEC_DIGITS; i++) begin
            if (r_bcd[i*4 +: 4] >= 4'd5) begin
                adj_bcd[i*4 +: 4] = r_bcd[i*4 +: 4] + 4'd3;
            end else begin
                adj_bcd[i*4 +: 4] = r_bcd[i*4 +: 4];
            end
        end
    end

    // binary and digit shift registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bin <= i_value;
            if (i_cmd.hex) begin
                r_bcd <= {i_value, 16'h0000};
                r_rem <= iaf_pkg::REM_HEX;
            end else begin
                r_bcd <= '0;
                r_rem <= iaf_pkg::REM_DEC;
            end
        end else if (i_cmd.dabble) begin
            r_bcd <= {adj_bcd[iaf_pkg::BCD_BITS-2:0], r_bin[iaf_pkg::BIN_BITS-1]};
            r_bin <= {r_bin[iaf_pkg::BIN_BITS-2:0], 1'b0};
        end else if (i_cmd.skip || i_cmd.emit) begin
            r_bcd <= {r_bcd[iaf_pkg::BCD_BITS-5:0], 4'h0};
            r_rem <= r_rem - 5'd1;
        end
    end

    // output beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            o_valid <= 1'b1;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_char_code <= iaf_pkg::digit_to_ascii(top_digit);
            o_last <= (r_rem == 5'd1);
        end
    end

endmodule

`default_nettype wire

>>> rtl/integer_to_ascii_formatter.sv
`default_nettype none

// channel | direction | handshake         | payload
// input   | in        | i_valid / o_stall | i_func, i_value
// output  | out       | o_valid / i_stall | o_char_code, o_last
//
// decimal: a load, then shift-and-add-three conversion over all 64 bits, then
//   the twenty digits, leading zeros skipped and the rest sent as beats
// hexadecimal: a load, then the sixteen digits, each skipped or sent as a beat
// reset clears the controller and the output valid; a stalled output beat
//   holds and the controller waits, and the next item is taken while the
//   final beat still waits to be read
module integer_to_ascii_formatter (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_func,
    input  wire logic [63:0] i_value,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [6:0]       o_char_code,
    output logic             o_last
);

    iaf_pkg::t_cmd cmd;
    iaf_pkg::t_sts sts;

    // sequencer
    iaf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_func  (i_func),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // conversion and output datapath
    iaf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_value     (i_value),
        .o_sts       (sts),
        .o_valid     (o_valid),
        .o_char_code (o_char_code),
        .o_last      (o_last),
        .i_stall     (i_stall)
    );

endmodule

`default_nettype wire

>>> rtl/iaf_checker.sv
`default_nettype none

`include "assert_macros.svh"

module iaf_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_stall,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic [6:0] o_char_code,
    input wire logic       o_last
);

    logic char_ok;

    // digit or upper case hex letter
    assign char_ok = (o_char_code >= 7'd48 && o_char_code <= 7'd57) ||
                     (o_char_code >= 7'd65 && o_char_code <= 7'd70);

    // a held beat keeps its payload
    `CHK_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable({o_char_code, o_last}))

    // every beat carries a digit character
    `CHK_SAME(a_char, i_clk, i_rst_n, o_valid, char_ok)

    // a taken item keeps the input side busy
    `CHK_NEXT(a_busy, i_clk, i_rst_n, i_valid && !o_stall, o_stall)

    // reset empties the output register
    `CHK_NEXT_ALWAYS(a_rst, i_clk, !i_rst_n, !o_valid)

endmodule

bind integer_to_ascii_formatter iaf_checker u_iaf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_char_code (o_char_code),
    .o_last      (o_last)
);

`default_nettype wire

>>> verif/tb_top.sv
`default_nettype none

module tb_top;

    // radix select and ascii bases
    localparam logic RADIX_DEC = 1'b0;
    localparam logic RADIX_HEX = 1'b1;
    localparam logic [6:0] CHAR_ZERO = 7'd48;
    localparam logic [6:0] CHAR_UPPER_A = 7'd65;
    localparam int MAX_DIGITS = 20;

    // run shape
    localparam int RANDOM_ITEMS = 250;
    localparam int QUIET_ITEMS = 40;
    localparam int DRAIN_CYCLES = 120;
    localparam int NUM_VECTORS = 21;

    typedef struct packed {
        logic [6:0] code;
        logic       last;
    } digit_beat_t;

    typedef struct {
        logic        func;
        logic [63:0] value;
        string       text;
    } vector_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_func;
    logic [63:0] i_value;
    logic        o_valid;
    logic        i_stall;
    logic [6:0]  o_char_code;
    logic        o_last;

    digit_beat_t digit_beats_due[$];
    int          fail_count = 0;
    int          items_sent = 0;
    int          hex_items = 0;
    int          beats_seen = 0;
    bit          idle_on = 1'b1;
    int          stall_left = 0;

    // directed numbers; text given where the digits are obvious
    vector_t directed_vectors [NUM_VECTORS] = '{
        '{RADIX_DEC, 64'd0, "0"},
        '{RADIX_HEX, 64'd0, "0"},
        '{RADIX_DEC, 64'd1, "1"},
        '{RADIX_HEX, 64'd1, "1"},
        '{RADIX_DEC, 64'hFFFF_FFFF_FFFF_FFFF, "18446744073709551615"},
        '{RADIX_HEX, 64'hFFFF_FFFF_FFFF_FFFF, "FFFFFFFFFFFFFFFF"},
        '{RADIX_HEX, 64'h8000_0000_0000_0000, "8000000000000000"},
        '{RADIX_DEC, 64'd9, ""},
        '{RADIX_DEC, 64'd10, ""},
        '{RADIX_HEX, 64'd10, ""},
        '{RADIX_HEX, 64'd15, ""},
        '{RADIX_HEX, 64'd16, ""},
        '{RADIX_DEC, 64'd100, ""},
        '{RADIX_DEC, 64'd9999999999999999999, ""},
        '{RADIX_DEC, 64'd10000000000000000000, ""},
        '{RADIX_DEC, 64'h8000_0000_0000_0000, ""},
        '{RADIX_HEX, 64'h0123_4567_89AB_CDEF, ""},
        '{RADIX_HEX, 64'hFEDC_BA98_7654_3210, ""},
        '{RADIX_HEX, 64'hAAAA_AAAA_AAAA_AAAA, ""},
        '{RADIX_DEC, 64'h5555_5555_5555_5555, ""},
        '{RADIX_DEC, 64'd1234567890, ""}
    };

    integer_to_ascii_formatter DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_func      (i_func),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_char_code (o_char_code),
        .o_last      (o_last)
    );

    // clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // digits of one number, most significant first, queued as expected beats
    function automatic void predict_digits(input logic func, input logic [63:0] value);
        logic [3:0]  rev [MAX_DIGITS];
        logic [63:0] rest;
        logic [3:0]  d;
        int          count;
        int          k;
        digit_beat_t b;
        rest = value;
        count = 0;
        if (rest == 64'd0) begin
            rev[0] = 4'd0;
            count = 1;
        end else begin
            while (rest != 64'd0 && count < MAX_DIGITS) begin
                if (func == RADIX_HEX) begin
                    rev[count] = rest[3:0];
                    rest = rest >> 4;
                end else begin
                    rev[count] = 4'(rest % 64'd10);
                    rest = rest / 64'd10;
                end
                count++;
            end
        end
        for (k = 0; k < count; k++) begin
            d = rev[count - 1 - k];
            b.code = (d < 4'd10) ? CHAR_ZERO + 7'(d) : CHAR_UPPER_A + 7'(d) - 7'd10;
            b.last = (k == count - 1);
            digit_beats_due.push_back(b);
        end
    endfunction

    // present one number and hold it until taken; empty text means predict
    task automatic send_number(input logic func, input logic [63:0] value,
                               input string text);
        int          gap;
        int          k;
        digit_beat_t b;
        if (idle_on && $urandom_range(0, 2) == 0) begin
            gap = $urandom_range(1, 17);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= func;
        i_value <= value;
        do @(posedge i_clk); while (o_stall);
        if (text.len() == 0) begin
            predict_digits(func, value);
        end else begin
            for (k = 0; k < text.len(); k++) begin
                b.code = 7'(text[k]);
                b.last = (k == text.len() - 1);
                digit_beats_due.push_back(b);
            end
        end
        items_sent++;
        if (func == RADIX_HEX) begin
            hex_items++;
        end
        @(negedge i_clk);
    endtask

    // output back-pressure in bursts
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 17);
        end
        i_stall <= (stall_left > 0);
    end

    // compare each taken beat with the oldest expected one
    always @(posedge i_clk) begin
        digit_beat_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            beats_seen++;
            if (digit_beats_due.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected beat code %0d last %0b",
                         $time, o_char_code, o_last);
            end else begin
                want = digit_beats_due.pop_front();
                if (o_char_code !== want.code) begin
                    fail_count++;
                    $display("%0t: char_code expected %0d actual %0d",
                             $time, want.code, o_char_code);
                end
                if (o_last !== want.last) begin
                    fail_count++;
                    $display("%0t: last expected %0b actual %0b",
                             $time, want.last, o_last);
                end
            end
        end
    end

    // stimulus and end of run
    initial begin
        int          n;
        int          k;
        int          sh;
        logic        f;
        logic [63:0] raw;
        logic [63:0] v;
        logic [63:0] p;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_func = 1'b0;
        i_value = 64'd0;
        i_stall = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (n = 0; n < NUM_VECTORS; n++) begin
            send_number(directed_vectors[n].func, directed_vectors[n].value,
                        directed_vectors[n].text);
        end

        // random numbers of mixed length, quiet handshakes in every third run of 35 and at the end
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            idle_on = (n < RANDOM_ITEMS - QUIET_ITEMS) && ((n / 35) % 3 != 2);
            f = 1'($urandom_range(0, 1));
            raw = {$urandom, $urandom};
            case ($urandom_range(0, 3))
                0: begin
                    v = raw;
                end
                1: begin
                    sh = $urandom_range(0, 63);
                    v = raw >> sh;
                end
                2: begin
                    // around a power of ten, where digit count changes
                    k = $urandom_range(1, 19);
                    p = 64'd1;
                    repeat (k) p = p * 64'd10;
                    v = p + 64'($urandom_range(0, 2)) - 64'd1;
                end
                default: begin
                    v = 64'($urandom_range(0, 20));
                end
            endcase
            send_number(f, v, "");
        end
        i_valid <= 1'b0;

        while (digit_beats_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("formatted %0d numbers (%0d hexadecimal, %0d decimal), %0d digit beats",
                 items_sent, hex_items, items_sent - hex_items, beats_seen);
        $display("covered zero, full-scale, powers of ten and random lengths under stalls");
        if (fail_count == 0) begin
            $display("integer_to_ascii_formatter regression: pass");
        end else begin
            $display("integer_to_ascii_formatter regression: fail");
        end
        $finish;
    end

    // watchdog
    initial begin
        #10_000_000;
        $display("integer_to_ascii_formatter regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
+incdir+rtl
rtl/iaf_pkg.sv
rtl/iaf_ctrl.sv
rtl/iaf_dp.sv
rtl/integer_to_ascii_formatter.sv
rtl/iaf_checker.sv
verif/tb_top.sv
